// ===== hdl/periodic_callback_timer_table_defines.svh =====
// Assertion macros shared by the checker
`ifndef PERIODIC_CALLBACK_TIMER_TABLE_DEFINES_SVH
`define PERIODIC_CALLBACK_TIMER_TABLE_DEFINES_SVH
// implication checked on every edge out of reset
`define PCT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define PCT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== hdl/pct_pkg.sv =====
package pct_pkg;
  localparam int SlotCountDef = 32;
  localparam int HandleW = 16;
  localparam int TimeW = 64;
  localparam int IvW = 32;
  localparam int StepW = 16;
  localparam logic [9:0] Scale = 10'd1000;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SCAN,
    ST_EMIT,
    ST_DONE
  } state_t;

  // request travelling down the chain of slot cells
  typedef struct packed {
    logic               vld;
    kind_t              kind;
    logic [HandleW-1:0] handle;
    logic [TimeW-1:0]   ivl;
    logic [TimeW-1:0]   now;
    logic               first_free; // set once the add has taken the slot at used_count
    logic               hit;        // duplicate seen or remove done
  } req_t;

  // result of one cell's work
  typedef struct packed {
    logic               fire;
    logic [HandleW-1:0] handle;
  } evt_t;
endpackage

// ===== hdl/pct_cell.sv =====
module pct_cell
  import pct_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic step_en,   // this cell steps on the request on req_i this cycle
  input  logic is_tail,   // slot at used_count-1
  input  logic in_use,    // slot below used_count
  input  logic is_free,   // slot at used_count
  input  req_t req_i,
  output req_t req_o,
  output evt_t evt_o,
  output logic shrink_o
);
  logic [HandleW-1:0] hnd_r, hnd_nxt;
  logic act_r, act_nxt;
  logic [TimeW-1:0] ivl_r, ivl_nxt, lf_r, lf_nxt;
  logic match, fire;

  assign match = in_use && hnd_r == req_i.handle && req_i.handle != '0;
  assign fire = in_use && act_r && hnd_r != '0 && (req_i.now - lf_r) >= ivl_r;

  // per-slot update; the firing flag is shown whether or not the cell steps
  always_comb begin
    hnd_nxt = hnd_r; act_nxt = act_r; ivl_nxt = ivl_r; lf_nxt = lf_r;
    req_o = req_i;
    evt_o = '{fire: 1'b0, handle: '0};
    shrink_o = 1'b0;
    if (req_i.vld && req_i.kind == KIND_TICK && fire) evt_o = '{fire: 1'b1, handle: hnd_r};
    if (step_en && req_i.vld) begin
      case (req_i.kind)
        KIND_TICK: begin
          if (fire) lf_nxt = req_i.now;
        end
        KIND_ADD: begin
          if (match) req_o.hit = 1'b1;
          if (is_free && !req_i.hit && !match && req_i.handle != '0) begin
            hnd_nxt = req_i.handle; ivl_nxt = req_i.ivl;
            lf_nxt = req_i.now; act_nxt = 1'b1;
            req_o.first_free = 1'b1;
          end
        end
        KIND_REMOVE: begin
          if (match && !req_i.hit) begin
            hnd_nxt = '0; act_nxt = 1'b0;
            req_o.hit = 1'b1;
            shrink_o = is_tail;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hnd_r <= '0; act_r <= 1'b0;
    end else begin
      hnd_r <= hnd_nxt; act_r <= act_nxt;
    end
    ivl_r <= ivl_nxt; lf_r <= lf_nxt;
  end
endmodule

// ===== hdl/periodic_callback_timer_table.sv =====
// An accepted item passes through ST_MUL (scale the interval), then ST_SCAN (the request
// walks the chain of slot cells, one cell at a time), then ST_DONE (finish, final
// result registered); earlier firing results go out during the walk.
// One item at a time: no new item is taken until the last is back in ST_IDLE; a held
// result can stall the walk and hold ST_DONE.
// Reset (synchronous, rst_n low): running time, count, handles and flags cleared.
module periodic_callback_timer_table
  import pct_pkg::*;
#(
  parameter int SLOT_COUNT = SlotCountDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // kind[1:0], handle[17:2], interval[49:18]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // ok[0], fired[1], fired_handle[17:2], now_time[81:18]
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);

  state_t st_r, st_nxt;
  logic [StepW-1:0] step_r;
  logic [TimeW-1:0] now_r, now_nxt;
  logic [TimeW-1:0] onow_r, onow_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  req_t req_r, req_nxt;
  logic ok_r, ok_nxt, fired_r, fired_nxt, last_r, last_nxt, ov_r, ov_nxt;
  logic [HandleW-1:0] fh_r, fh_nxt;
  logic [HandleW-1:0] pend_h_r, pend_h_nxt;
  logic pend_r, pend_nxt;

  req_t cell_out [SLOT_COUNT];
  evt_t evt [SLOT_COUNT];
  logic shr [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] sel;
  logic stall;

  // cells step one at a time; the walking request is chained by idx
  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
    assign sel[g] = st_r == ST_SCAN && idx_r == IW'(g) && !stall;
    pct_cell u_cell (
      .clk, .rst_n,
      .step_en (sel[g]),
      .is_tail (CW'(g) + CW'(1) == cnt_r),
      .in_use  (CW'(g) < cnt_r),
      .is_free (CW'(g) == cnt_r),
      .req_i   (req_r),
      .req_o   (cell_out[g]),
      .evt_o   (evt[g]),
      .shrink_o(shr[g])
    );
  end

  req_t cur_o;
  evt_t cur_e;
  logic cur_s;
  assign cur_o = cell_out[idx_r];
  assign cur_e = evt[idx_r];
  assign cur_s = shr[idx_r];

  // a firing that needs the still-held result register waits in place
  assign stall = st_r == ST_SCAN && cur_e.fire && pend_r && ov_r && !out_tready;

  always_comb begin
    st_nxt = st_r; now_nxt = now_r; cnt_nxt = cnt_r; idx_nxt = idx_r;
    req_nxt = req_r; ok_nxt = ok_r; fired_nxt = fired_r;
    fh_nxt = fh_r; last_nxt = last_r; ov_nxt = ov_r; onow_nxt = onow_r;
    pend_nxt = pend_r; pend_h_nxt = pend_h_r;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    case (st_r)
      ST_IDLE: if (in_tvalid) begin
        req_nxt = '0;
        req_nxt.vld = 1'b1;
        req_nxt.kind = kind_t'(in_tdata[1:0]);
        req_nxt.handle = in_tdata[17:2];
        req_nxt.ivl = TimeW'(in_tdata[49:18]);
        req_nxt.now = now_r + TimeW'(step_r);
        pend_nxt = 1'b0; idx_nxt = '0;
        st_nxt = ST_MUL;
      end
      ST_MUL: begin
        req_nxt.ivl = req_r.ivl[IvW-1:0] * TimeW'(Scale);
        // only a tick advances time; an add stamps the current time
        if (req_r.kind == KIND_TICK) now_nxt = req_r.now;
        else req_nxt.now = now_r;
        st_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (!stall) begin
          req_nxt = cur_o;
          if (cur_s) cnt_nxt = cnt_r - CW'(1);
          if (cur_e.fire) begin
            if (pend_r) begin
              ov_nxt = 1'b1; ok_nxt = 1'b1; fired_nxt = 1'b1;
              fh_nxt = pend_h_r; last_nxt = 1'b0; onow_nxt = now_r;
            end
            pend_nxt = 1'b1; pend_h_nxt = cur_e.handle;
          end
          if (idx_r == IW'(SLOT_COUNT - 1)) st_nxt = ST_DONE;
          else idx_nxt = idx_r + IW'(1);
        end
      end
      ST_DONE: if (!ov_r || out_tready) begin
        ov_nxt = 1'b1; last_nxt = 1'b1; onow_nxt = now_r;
        fired_nxt = pend_r; fh_nxt = pend_r ? pend_h_r : '0;
        case (req_r.kind)
          KIND_TICK:   ok_nxt = 1'b1;
          KIND_ADD:    ok_nxt = req_r.first_free;
          KIND_REMOVE: ok_nxt = req_r.hit;
          default:     ok_nxt = 1'b0;
        endcase
        if (req_r.kind == KIND_ADD && req_r.first_free) cnt_nxt = cnt_r + CW'(1);
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // the cells only step on the request in scan; the stall above holds idx
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; now_r <= '0; cnt_r <= '0; ov_r <= 1'b0;
      step_r <= '0; pend_r <= 1'b0; idx_r <= '0;
    end else begin
      st_r <= st_nxt; now_r <= now_nxt; cnt_r <= cnt_nxt; ov_r <= ov_nxt;
      pend_r <= pend_nxt; idx_r <= idx_nxt;
      if (cfg_we) step_r <= cfg_wdata;
    end
    req_r <= req_nxt; ok_r <= ok_nxt; fired_r <= fired_nxt;
    fh_r <= fh_nxt; last_r <= last_nxt; pend_h_r <= pend_h_nxt; onow_r <= onow_nxt;
  end

  assign in_tready = st_r == ST_IDLE;
  assign out_tvalid = ov_r;
  assign out_tlast = last_r;
  assign out_tdata = {6'd0, onow_r, fh_r, fired_r, ok_r};
endmodule

// ===== hdl/pct_checker.sv =====
`include "periodic_callback_timer_table_defines.svh"
module pct_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [87:0] out_tdata,
  input logic        out_tlast
);
  // no new item while the block is busy
  `PCT_ASSERT_NXT(a_busy, in_tvalid && in_tready, !in_tready, "took item while busy")
  // a firing result carries a handle
  `PCT_ASSERT_IMP(a_fh, out_tvalid && out_tdata[1], out_tdata[17:2] != 16'd0, "null fired")
  // non-firing results carry no handle and are the last result of their item
  `PCT_ASSERT_IMP(a_nf, out_tvalid && !out_tdata[1], out_tdata[17:2] == 16'd0 && out_tlast,
    "bad idle result")
  // stalled result holds
  `PCT_ASSERT_NXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata),
    "result dropped")
endmodule

bind periodic_callback_timer_table pct_checker u_pct_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata, .out_tlast
);

// ===== test/periodic_callback_timer_table_test.sv =====
module periodic_callback_timer_table_test;
  import pct_pkg::*;

  localparam int Slots = SlotCountDef;

  typedef struct {
    kind_t             kind;
    logic [15:0]       handle;
    logic [31:0]       interval;
  } req_item_t;

  typedef struct {
    logic        ok;
    logic        fired;
    logic [15:0] fired_handle;
    logic [63:0] now_time;
    logic        last;
  } timer_event_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;   // kind[1:0], handle[17:2], interval[49:18]
  logic        out_tvalid;
  logic        out_tready;
  logic [87:0] out_tdata;  // ok[0], fired[1], fired_handle[17:2], now_time[81:18]
  logic        out_tlast;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  periodic_callback_timer_table uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predictor state
  logic [15:0] step_now;
  logic [63:0] clock_now;
  int          used_now;
  logic [15:0] tab_handle [Slots];
  logic        tab_active [Slots];
  logic [63:0] tab_ivl [Slots];
  logic [63:0] tab_last [Slots];

  req_item_t    pending_q[$];
  timer_event_t expected_q[$];
  int           errors;
  int           send_idle_pct;
  int           recv_idle_pct;
  bit           hold_send;
  longint       cycles;

  function automatic timer_event_t make_event(logic ok, logic fired, logic [15:0] h,
                                              logic lst);
    timer_event_t e;
    e.ok = ok;
    e.fired = fired;
    e.fired_handle = h;
    e.now_time = clock_now;
    e.last = lst;
    return e;
  endfunction

  function automatic logic table_add(logic [15:0] h, logic [31:0] iv);
    if (h == 16'd0 || used_now >= Slots) return 1'b0;
    for (int i = 0; i < used_now; i++)
      if (tab_handle[i] == h) return 1'b0;
    tab_handle[used_now] = h;
    tab_ivl[used_now] = 64'(iv) * 64'd1000;
    tab_last[used_now] = clock_now;
    tab_active[used_now] = 1'b1;
    used_now++;
    return 1'b1;
  endfunction

  function automatic logic table_remove(logic [15:0] h);
    if (h == 16'd0) return 1'b0;
    for (int i = 0; i < used_now; i++)
      if (tab_handle[i] == h) begin
        tab_active[i] = 1'b0;
        tab_handle[i] = 16'd0;
        if (i == used_now - 1) used_now--;
        return 1'b1;
      end
    return 1'b0;
  endfunction

  // work out the results of one accepted item
  function automatic void predict_timer(req_item_t r);
    timer_event_t e;
    int n;
    n = 0;
    case (r.kind)
      KIND_TICK: begin
        clock_now = clock_now + 64'(step_now);
        for (int i = 0; i < used_now; i++)
          if (tab_active[i] && tab_handle[i] != 16'd0 &&
              (clock_now - tab_last[i]) >= tab_ivl[i]) begin
            tab_last[i] = clock_now;
            expected_q.push_back(make_event(1'b1, 1'b1, tab_handle[i], 1'b0));
            n++;
          end
        if (n == 0) expected_q.push_back(make_event(1'b1, 1'b0, 16'd0, 1'b1));
        else begin
          e = expected_q.pop_back();
          e.last = 1'b1;
          expected_q.push_back(e);
        end
      end
      KIND_ADD:
        expected_q.push_back(make_event(table_add(r.handle, r.interval), 1'b0, 16'd0, 1'b1));
      KIND_REMOVE:
        expected_q.push_back(make_event(table_remove(r.handle), 1'b0, 16'd0, 1'b1));
      default:
        expected_q.push_back(make_event(1'b0, 1'b0, 16'd0, 1'b1));
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
    end else begin
      if (in_tvalid && in_tready) predict_timer(pending_q.pop_front());
      if ((!in_tvalid || in_tready) || !in_tvalid) begin
        if ((in_tvalid && !in_tready)) begin
          // hold current item
        end else if (pending_q.size() > (in_tvalid && in_tready ? 0 : 0) && !hold_send &&
                     $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata <= {6'd0, pending_q[0].interval, pending_q[0].handle, pending_q[0].kind};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    timer_event_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.ok = out_tdata[0];
        got.fired = out_tdata[1];
        got.fired_handle = out_tdata[17:2];
        got.now_time = out_tdata[81:18];
        got.last = out_tlast;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected item ok=%b fired=%b h=%h t=%h last=%b", $time,
                   got.ok, got.fired, got.fired_handle, got.now_time, got.last);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.ok !== want.ok || got.fired !== want.fired ||
              got.fired_handle !== want.fired_handle || got.now_time !== want.now_time ||
              got.last !== want.last) begin
            $display("%0t: expected ok=%b fired=%b h=%h t=%h last=%b", $time,
                     want.ok, want.fired, want.fired_handle, want.now_time, want.last);
            $display("%0t: actual   ok=%b fired=%b h=%h t=%h last=%b", $time,
                     got.ok, got.fired, got.fired_handle, got.now_time, got.last);
            errors++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic queue_item(kind_t k, logic [15:0] h, logic [31:0] iv);
    req_item_t r;
    r.kind = k;
    r.handle = h;
    r.interval = iv;
    pending_q.push_back(r);
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || in_tvalid || expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_step(logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    step_now <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // random burst: mostly ticks over a small pool of handles
  task automatic random_burst(int count);
    int r;
    logic [15:0] h;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      h = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(12));
      if (r < 55) queue_item(KIND_TICK, 16'($urandom), 32'($urandom));
      else if (r < 75) queue_item(KIND_ADD, h,
                                  ($urandom_range(7) == 0) ? 32'($urandom)
                                                           : 32'($urandom_range(40)));
      else if (r < 95) queue_item(KIND_REMOVE, h, 32'($urandom));
      else queue_item(KIND_NONE, 16'($urandom), 32'($urandom));
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    hold_send = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    step_now = 16'd0;
    clock_now = 64'd0;
    used_now = 0;
    for (int i = 0; i < Slots; i++) begin
      tab_handle[i] = 16'd0;
      tab_active[i] = 1'b0;
      tab_ivl[i] = 64'd0;
      tab_last[i] = 64'd0;
    end
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 16'd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: step zero, zero interval, null, duplicate, remove cases
    queue_item(KIND_TICK, 16'd0, 32'd0);
    queue_item(KIND_ADD, 16'd0, 32'd5);
    queue_item(KIND_ADD, 16'hFFFF, 32'd0);
    queue_item(KIND_ADD, 16'hFFFF, 32'd3);
    queue_item(KIND_ADD, 16'd1, 32'hFFFF_FFFF);
    queue_item(KIND_TICK, 16'hFFFF, 32'hFFFF_FFFF);
    queue_item(KIND_REMOVE, 16'd0, 32'd0);
    queue_item(KIND_REMOVE, 16'd77, 32'd0);
    queue_item(KIND_NONE, 16'hFFFF, 32'hFFFF_FFFF);
    wait_drained();
    set_step(16'hFFFF);
    // fill the table with zero-interval handles and add past its end, then tick
    for (int i = 2; i <= Slots; i++) queue_item(KIND_ADD, 16'(i), 32'd0);
    queue_item(KIND_ADD, 16'd100, 32'd1);
    queue_item(KIND_TICK, 16'd0, 32'd0);
    queue_item(KIND_REMOVE, 16'd1, 32'd0);
    queue_item(KIND_REMOVE, 16'(Slots), 32'd0);
    queue_item(KIND_ADD, 16'd200, 32'd0);
    queue_item(KIND_TICK, 16'd0, 32'd0);
    wait_drained();
    // remove handles 1 to Slots and 200; handle 16'hFFFF stays
    for (int i = 1; i <= Slots; i++) queue_item(KIND_REMOVE, 16'(i), 32'd0);
    queue_item(KIND_REMOVE, 16'd200, 32'd0);
    wait_drained();
    // removing from the end only shrinks the count from the top: keep churn moderate
    set_step(16'd1000);
    send_idle_pct = 12;
    recv_idle_pct = 50;
    random_burst(170);
    wait_drained();
    hold_send = 1'b1;
    queue_item(KIND_TICK, 16'd0, 32'd0);
    repeat (20) @(posedge clk);
    hold_send = 1'b0;
    wait_drained();
    set_step(16'($urandom));
    send_idle_pct = 50;
    recv_idle_pct = 12;
    random_burst(170);
    wait_drained();
    set_step(16'd0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_burst(80);
    wait_drained();
    set_step(16'hFFFF);
    random_burst(80);
    wait_drained();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== periodic_callback_timer_table.f =====
+incdir+hdl
hdl/pct_pkg.sv
hdl/pct_cell.sv
hdl/periodic_callback_timer_table.sv
hdl/pct_checker.sv
test/periodic_callback_timer_table_test.sv
